/* hdl/vn3_pkg.sv */
// Types shared by the 3-d vector normalizer: channel payloads and cell state.
package vn3_pkg;

	typedef struct packed {
		logic signed [31:0] x_in;
		logic signed [31:0] y_in;
		logic signed [31:0] z_in;
	} vec_t;

	typedef struct packed {
		logic signed [31:0] x_unit;
		logic signed [31:0] y_unit;
		logic signed [31:0] z_unit;
		logic [31:0]        magnitude;
		logic               zero_vector;
	} res_t;

	typedef struct packed {
		logic [34:0]      rem;
		logic [31:0]      root;
		logic [63:0]      rad;
		logic [2:0][31:0] abs_v;
		logic [2:0]       neg;
	} sq_t;

	typedef struct packed {
		logic [2:0][31:0] rem;
		logic [2:0]       lsb;
		logic [2:0][30:0] quo;
		logic [31:0]      mag;
		logic [2:0]       neg;
	} dv_t;

endpackage

/* hdl/vn3_sqrt_cell.sv */
// One cell of the square root chain: settles one bit of the root per stage.
module vn3_sqrt_cell
	import vn3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic d_valid,
	input  sq_t  d,
	output logic q_valid,
	output sq_t  q
);

	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic        ge;
	sq_t         nxt;

	always_comb begin
		rem_sh = {d.rem[32:0], d.rad[63:62]};
		trial  = {1'b0, d.root, 2'b01};
		ge     = (rem_sh >= trial);
		nxt       = d;
		nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
		nxt.root  = {d.root[30:0], ge};
		nxt.rad   = {d.rad[61:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (en) begin
			q_valid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

/* hdl/vn3_div_cell.sv */
// One cell of the division chain: one quotient bit for each of the three lanes.
module vn3_div_cell
	import vn3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic d_valid,
	input  dv_t  d,
	output logic q_valid,
	output dv_t  q
);

	logic [2:0][32:0] t;
	logic [2:0]       ge;
	dv_t              nxt;

	always_comb begin
		nxt     = d;
		nxt.lsb = 3'b000;
		for (int i = 0; i < 3; i++) begin
			t[i]       = {d.rem[i], d.lsb[i]};
			ge[i]      = (t[i] >= {1'b0, d.mag});
			nxt.rem[i] = ge[i] ? 32'(t[i] - {1'b0, d.mag}) : t[i][31:0];
			nxt.quo[i] = {d.quo[i][29:0], ge[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid <= 1'b0;
		end else if (en) begin
			q_valid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

/* hdl/vector_normalize_3d.sv */
// Top level of the 3-d vector normalizer: front stages, cell chains, output register.
//
// Usage: a vector (Q16.16 x, y, z) transfers on vec when vec_valid is high
// and vec_stall is low. The result (Q1.30 unit components, Q16.16 magnitude,
// zero flag) transfers on res when res_valid is high and res_stall is low.
// From input transfer to result valid a vector passes through three front
// stages (absolute value, squares, sum), 32 square root cells producing one
// root bit each, 31 division cells producing one quotient bit per lane, and
// the output register. Throughput is one vector per cycle when not stalled.
// The whole pipeline advances together; it holds while a result waits on a
// stalled receiver, and vec_stall is raised for that time.
// Reset clears every valid bit, so the block starts empty; no data is kept
// between vectors.
module vector_normalize_3d
	import vn3_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic vec_valid,
	output logic vec_stall,
	input  vec_t vec,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int SqCells = 32;
	localparam int DvCells = 31;

	logic en;
	assign en        = !(res_valid && res_stall);
	assign vec_stall = !en;

	logic             v_s1, v_s2, v_s3;
	logic [2:0][31:0] abs_s1, abs_s2;
	logic [2:0]       neg_s1, neg_s2, neg_s3;
	logic [2:0][63:0] sq_s2;
	logic [2:0][31:0] abs_s3;
	logic [63:0]      sum_s3;
	logic [2:0][31:0] raw;

	assign raw[0] = vec.x_in;
	assign raw[1] = vec.y_in;
	assign raw[2] = vec.z_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= vec_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw[i][31];
				abs_s1[i] <= raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
				sq_s2[i]  <= 64'(abs_s1[i]) * 64'(abs_s1[i]);
			end
			abs_s2 <= abs_s1;
			neg_s2 <= neg_s1;
			abs_s3 <= abs_s2;
			neg_s3 <= neg_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		end
	end

	sq_t  sq_d [SqCells+1];
	logic sq_v [SqCells+1];
	sq_t  sq_in;

	always_comb begin
		sq_in.rem   = '0;
		sq_in.root  = '0;
		sq_in.rad   = sum_s3;
		sq_in.abs_v = abs_s3;
		sq_in.neg   = neg_s3;
	end
	assign sq_d[0] = sq_in;
	assign sq_v[0] = v_s3;

	for (genvar c = 0; c < SqCells; c++) begin : g_sq
		vn3_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.d_valid (sq_v[c]),
			.d       (sq_d[c]),
			.q_valid (sq_v[c+1]),
			.q       (sq_d[c+1])
		);
	end

	dv_t  dv_d [DvCells+1];
	logic dv_v [DvCells+1];
	dv_t  dv_in;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dv_in.rem[i] = {1'b0, sq_d[SqCells].abs_v[i][31:1]};
			dv_in.lsb[i] = sq_d[SqCells].abs_v[i][0];
		end
		dv_in.quo = '0;
		dv_in.mag = sq_d[SqCells].root;
		dv_in.neg = sq_d[SqCells].neg;
	end
	assign dv_d[0] = dv_in;
	assign dv_v[0] = sq_v[SqCells];

	for (genvar c = 0; c < DvCells; c++) begin : g_dv
		vn3_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.d_valid (dv_v[c]),
			.d       (dv_d[c]),
			.q_valid (dv_v[c+1]),
			.q       (dv_d[c+1])
		);
	end

	logic             zero;
	logic [2:0][31:0] unit;

	always_comb begin
		zero = (dv_d[DvCells].mag == 32'd0);
		for (int i = 0; i < 3; i++) begin
			if (zero) begin
				unit[i] = '0;
			end else if (dv_d[DvCells].neg[i]) begin
				unit[i] = ~{1'b0, dv_d[DvCells].quo[i]} + 32'd1;
			end else begin
				unit[i] = {1'b0, dv_d[DvCells].quo[i]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (en) begin
			res_valid <= dv_v[DvCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res.x_unit      <= unit[0];
			res.y_unit      <= unit[1];
			res.z_unit      <= unit[2];
			res.magnitude   <= dv_d[DvCells].mag;
			res.zero_vector <= zero;
		end
	end

endmodule

/* test/testbench.sv */
// Self-checking testbench for the 3-d vector normalizer: random and directed vectors.
`timescale 1ns / 100ps

module testbench;
	import vn3_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic vec_valid = 1'b0;
	logic vec_stall;
	vec_t vec = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	vec_t pending_vecs[$];
	res_t expected_units[$];
	int errors = 0;
	int results_seen = 0;
	int zero_seen = 0;
	int cycles = 0;
	bit quiet_tail = 1'b0;
	bit hold_sender = 1'b0;
	bit in_taken = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	vector_normalize_3d uut (
		.clk(clk), .arst_n(arst_n), .vec_valid(vec_valid), .vec_stall(vec_stall),
		.vec(vec), .res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] floor_root(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [31:0] unit_lane(logic [31:0] comp, logic [63:0] mag);
		logic [63:0] a;
		logic [63:0] q;
		a = comp[31] ? {32'd0, -comp} : {32'd0, comp};
		q = (mag == 0) ? 64'd0 : (a << 30) / mag;
		if (comp[31]) q = -q;
		return q[31:0];
	endfunction

	function automatic res_t normalize(vec_t v);
		res_t r;
		logic [63:0] ax, ay, az, m;
		ax = v.x_in[31] ? {32'd0, -v.x_in} : {32'd0, v.x_in};
		ay = v.y_in[31] ? {32'd0, -v.y_in} : {32'd0, v.y_in};
		az = v.z_in[31] ? {32'd0, -v.z_in} : {32'd0, v.z_in};
		m = floor_root(ax * ax + ay * ay + az * az);
		r.x_unit = unit_lane(v.x_in, m);
		r.y_unit = unit_lane(v.y_in, m);
		r.z_unit = unit_lane(v.z_in, m);
		r.magnitude = m[31:0];
		r.zero_vector = (m == 0);
		return r;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch on %s at result %0d: got %h expected %h",
			field, results_seen, got, want);
	endtask

	function automatic logic [31:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) - 1;
			1: return $urandom_range(0, 65535) - 32768;
			2: return {$urandom_range(0, 1) ? 4'hF : 4'h0, 28'($urandom())};
			3: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (!vec_valid || in_taken) begin
				if (send_gap > 0) begin
					send_gap--;
					vec_valid <= 1'b0;
				end else if (!hold_sender && pending_vecs.size() > 0) begin
					vec <= pending_vecs[0];
					expected_units.push_back(normalize(pending_vecs[0]));
					pending_vecs.pop_front();
					vec_valid <= 1'b1;
					if (!quiet_tail && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 6);
				end else begin
					vec_valid <= 1'b0;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				res_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(0, 5);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		cycles++;
		in_taken = arst_n && vec_valid && !vec_stall;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_units.size() == 0) begin
				errors++;
				$display("unexpected result transfer: %h", res);
			end else begin
				want = expected_units.pop_front();
				if (res.x_unit !== want.x_unit) report("x_unit", res.x_unit, want.x_unit);
				if (res.y_unit !== want.y_unit) report("y_unit", res.y_unit, want.y_unit);
				if (res.z_unit !== want.z_unit) report("z_unit", res.z_unit, want.z_unit);
				if (res.magnitude !== want.magnitude)
					report("magnitude", res.magnitude, want.magnitude);
				if (res.zero_vector !== want.zero_vector)
					report("zero_vector", res.zero_vector, want.zero_vector);
				if (want.zero_vector) zero_seen++;
			end
			results_seen++;
		end
		if (cycles > 200000) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		vec_t v;
		logic [31:0] edges[6];
		edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
		pending_vecs.push_back('{32'h0, 32'h0, 32'h0});
		for (int i = 0; i < 6; i++) begin
			pending_vecs.push_back('{edges[i], 32'h0, 32'h0});
			pending_vecs.push_back('{32'h0, edges[i], 32'h0});
			pending_vecs.push_back('{32'h0, 32'h0, edges[i]});
		end
		pending_vecs.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
		pending_vecs.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
		pending_vecs.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h1});
		pending_vecs.push_back('{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF});
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_vecs.size() == 0);
		hold_sender = 1'b1;
		wait (expected_units.size() == 0);
		for (int i = 0; i < 1200; i++) begin
			v.x_in = rand_comp();
			v.y_in = rand_comp();
			v.z_in = rand_comp();
			if ($urandom_range(0, 49) == 0) v = '0;
			pending_vecs.push_back(v);
		end
		hold_sender = 1'b0;
		wait (pending_vecs.size() < 200);
		quiet_tail = 1'b1;
		wait (pending_vecs.size() == 0 && expected_units.size() == 0);
		repeat (100) @(posedge clk);
		$display("checked %0d normalized vectors, %0d of them zero vectors,", results_seen, zero_seen);
		$display("with component extremes and random stalls on both channels.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
